// ===== rtl/pbt_pkg.sv =====
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared constants and types of the pileup base tally block.
// ----------------------------------------------------------------------------
`default_nettype none

package pbt_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int OUT_W           = 16;
    localparam int NUM_TALLY       = 7;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

    // Tally lanes.
    localparam int TALLY_A    = 0;
    localparam int TALLY_C    = 1;
    localparam int TALLY_G    = 2;
    localparam int TALLY_T    = 3;
    localparam int TALLY_N    = 4;
    localparam int TALLY_DEL  = 5;
    localparam int TALLY_SKIP = 6;

    // Register word index (paddr bit 2).
    localparam logic REG_MIN_QUALITY = 1'b0;
    localparam logic REG_QC_ENABLE   = 1'b1;

    // Base symbols.
    localparam logic [7:0] CHAR_A_UC  = 8'h41;
    localparam logic [7:0] CHAR_A_LC  = 8'h61;
    localparam logic [7:0] CHAR_C_UC  = 8'h43;
    localparam logic [7:0] CHAR_C_LC  = 8'h63;
    localparam logic [7:0] CHAR_G_UC  = 8'h47;
    localparam logic [7:0] CHAR_G_LC  = 8'h67;
    localparam logic [7:0] CHAR_T_UC  = 8'h54;
    localparam logic [7:0] CHAR_T_LC  = 8'h74;
    localparam logic [7:0] CHAR_N_UC  = 8'h4E;
    localparam logic [7:0] CHAR_N_LC  = 8'h6E;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_LESS  = 8'h3C;
    localparam logic [7:0] CHAR_MORE  = 8'h3E;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_CHAR     = 2'd1,
        STATUS_COV_MISMATCH = 2'd2
    } status_t;

    typedef struct packed {
        logic [NUM_TALLY-1:0] inc;
        logic                 bad;
    } class_t;

endpackage

`default_nettype wire

// ===== rtl/pileup_base_tally.sv =====
// ----------------------------------------------------------------------------
// pileup_base_tally
// Counts the base symbols of one pileup sample and reports the tallies and a
// status on the item that closes the sample.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    base_char, quality_score,
//                                          declared_coverage, last_base, no_base
//  m_        out        m_valid/m_ready    count_a..count_deletion, status
//  apb       in/out     psel/penable       min_quality, quality_check_enable
//
// One item is taken per cycle but for the stall below. Items are registered
// on entry; an item that does not close a sample is tallied in the following
// cycle, and a closing item loads the result register. Reset clears the
// tallies, the configuration and both valid flags. A closing item waits
// in the entry register while the result register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pileup_base_tally #(
    parameter int COUNT_WIDTH = pbt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_base_char,
    input  wire logic [7:0]                        s_quality_score,
    input  wire logic [15:0]                       s_declared_coverage,
    input  wire logic                              s_last_base,
    input  wire logic                              s_no_base,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pbt_pkg::OUT_W-1:0]              m_count_a,
    output logic [pbt_pkg::OUT_W-1:0]              m_count_c,
    output logic [pbt_pkg::OUT_W-1:0]              m_count_g,
    output logic [pbt_pkg::OUT_W-1:0]              m_count_t,
    output logic [pbt_pkg::OUT_W-1:0]              m_count_n,
    output logic [pbt_pkg::OUT_W-1:0]              m_count_deletion,
    output logic [1:0]                             m_status,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pbt_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [pbt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pbt_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import pbt_pkg::*;

    localparam int LEN_W = COUNT_WIDTH + 1;
    localparam int CMP_W = (LEN_W > OUT_W) ? LEN_W : OUT_W;

    logic [7:0]             min_quality_reg;
    logic                   qc_enable_reg;

    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic [7:0]             in_quality_reg;
    logic [15:0]            in_cov_reg;
    logic                   in_last_reg;
    logic                   in_no_base_reg;

    logic [COUNT_WIDTH-1:0] tally_reg  [NUM_TALLY];
    logic [COUNT_WIDTH-1:0] tally_next [NUM_TALLY];
    logic [LEN_W-1:0]       length_reg;
    logic [LEN_W-1:0]       length_next;
    logic                   bad_reg;
    logic                   bad_next;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_count_reg [TALLY_DEL+1];
    logic [OUT_W-1:0]       out_count_next [TALLY_DEL+1];
    status_t                out_status_reg;
    status_t                status_next;

    class_t                 cls;
    logic                   consume;
    logic                   out_free;
    logic                   advance;
    logic                   no_real;
    logic                   one_mark;
    logic [NUM_TALLY-1:0]   inc;
    logic [CMP_W-1:0]       ext;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_quality_reg <= '0;
            qc_enable_reg   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_MIN_QUALITY: min_quality_reg <= pwdata[7:0];
                REG_QC_ENABLE:   qc_enable_reg   <= pwdata[0];
                default:         min_quality_reg <= min_quality_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_MIN_QUALITY: prdata[7:0] = min_quality_reg;
            REG_QC_ENABLE:   prdata[0]   = qc_enable_reg;
            default:         prdata      = '0;
        endcase
    end

    // Flow control.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg    <= s_base_char;
            in_quality_reg <= s_quality_score;
            in_cov_reg     <= s_declared_coverage;
            in_last_reg    <= s_last_base;
            in_no_base_reg <= s_no_base;
        end
    end

    pbt_classify u_classify (
        .base_char     (in_char_reg),
        .quality_score (in_quality_reg),
        .min_quality   (min_quality_reg),
        .qc_enable     (qc_enable_reg),
        .cls           (cls)
    );

    assign consume = !in_no_base_reg;
    assign inc     = consume ? cls.inc : '0;

    always_comb begin
        for (int i = 0; i < NUM_TALLY; i++) begin
            if (inc[i] && (tally_reg[i] != '1)) begin
                tally_next[i] = tally_reg[i] + 1'b1;
            end else begin
                tally_next[i] = tally_reg[i];
            end
        end
        if (consume && (length_reg != '1)) begin
            length_next = length_reg + 1'b1;
        end else begin
            length_next = length_reg;
        end
        bad_next = bad_reg || (consume && cls.bad);
    end

    // Status and clipped counts from the updated tallies.
    assign no_real = (tally_next[TALLY_A] == '0) && (tally_next[TALLY_C] == '0) &&
                     (tally_next[TALLY_G] == '0) && (tally_next[TALLY_T] == '0) &&
                     (tally_next[TALLY_N] == '0);
    assign one_mark =
        ((tally_next[TALLY_DEL] == COUNT_WIDTH'(1)) && (tally_next[TALLY_SKIP] == '0)) ||
        ((tally_next[TALLY_DEL] == '0) && (tally_next[TALLY_SKIP] == COUNT_WIDTH'(1)));

    always_comb begin
        priority if (bad_next) begin
            status_next = STATUS_BAD_CHAR;
        end else if ((CMP_W'(length_next) != CMP_W'(in_cov_reg)) &&
                     !(no_real && one_mark)) begin
            status_next = STATUS_COV_MISMATCH;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_comb begin
        ext = '0;
        for (int i = 0; i <= TALLY_DEL; i++) begin
            ext = CMP_W'(tally_next[i]);
            if (ext > CMP_W'(OUT_MAX)) begin
                out_count_next[i] = OUT_MAX;
            end else begin
                out_count_next[i] = ext[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TALLY; i++) begin
                tally_reg[i] <= '0;
            end
            length_reg <= '0;
            bad_reg    <= 1'b0;
        end else if (advance) begin
            if (in_last_reg) begin
                for (int i = 0; i < NUM_TALLY; i++) begin
                    tally_reg[i] <= '0;
                end
                length_reg <= '0;
                bad_reg    <= 1'b0;
            end else begin
                for (int i = 0; i < NUM_TALLY; i++) begin
                    tally_reg[i] <= tally_next[i];
                end
                length_reg <= length_next;
                bad_reg    <= bad_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            for (int i = 0; i <= TALLY_DEL; i++) begin
                out_count_reg[i] <= out_count_next[i];
            end
            out_status_reg <= status_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_count_a        = out_count_reg[TALLY_A];
    assign m_count_c        = out_count_reg[TALLY_C];
    assign m_count_g        = out_count_reg[TALLY_G];
    assign m_count_t        = out_count_reg[TALLY_T];
    assign m_count_n        = out_count_reg[TALLY_N];
    assign m_count_deletion = out_count_reg[TALLY_DEL];
    assign m_status         = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/pbt_classify.sv =====
// ----------------------------------------------------------------------------
// pbt_classify
// Decodes one base symbol into the lane it bumps, the invalid flag or neither.
// ----------------------------------------------------------------------------
`default_nettype none

module pbt_classify (
    input  wire logic [7:0]     base_char,
    input  wire logic [7:0]     quality_score,
    input  wire logic [7:0]     min_quality,
    input  wire logic           qc_enable,
    output pbt_pkg::class_t     cls
);
    import pbt_pkg::*;

    logic skip;

    assign skip = qc_enable && (quality_score < min_quality);

    always_comb begin
        cls = '0;
        if (skip) begin
            cls.inc[TALLY_SKIP] = 1'b1;
        end else begin
            unique case (base_char)
                CHAR_A_UC, CHAR_A_LC: cls.inc[TALLY_A]   = 1'b1;
                CHAR_C_UC, CHAR_C_LC: cls.inc[TALLY_C]   = 1'b1;
                CHAR_G_UC, CHAR_G_LC: cls.inc[TALLY_G]   = 1'b1;
                CHAR_T_UC, CHAR_T_LC: cls.inc[TALLY_T]   = 1'b1;
                CHAR_N_UC, CHAR_N_LC: cls.inc[TALLY_N]   = 1'b1;
                CHAR_STAR, CHAR_HASH: cls.inc[TALLY_DEL] = 1'b1;
                CHAR_LESS, CHAR_MORE: cls.bad            = 1'b0;
                default:              cls.bad            = 1'b1;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the pileup base tally block.
//
// A queue of pending items feeds a clocked driver on the s_ channel, and a
// clocked monitor on the m_ channel checks every result. The driver runs the
// expected tallies at the moment each item is accepted, so each sample that
// closes leaves one expected result behind. Both sides idle at random.
// Stimulus covers a short directed part and random phases under several
// quality settings written through APB.
// ----------------------------------------------------------------------------

module tb_top;

    import pbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 150;

    typedef struct packed {
        logic [7:0]  base_char;
        logic [7:0]  quality;
        logic [15:0] coverage;
        logic        last;
        logic        no_base;
    } pileup_item_t;

    typedef struct packed {
        logic [5:0][15:0] cnt;
        status_t          status;
    } tally_result_t;

    logic                  aclk                = 1'b0;
    logic                  aresetn             = 1'b0;
    logic                  s_valid             = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_base_char         = '0;
    logic [7:0]            s_quality_score     = '0;
    logic [15:0]           s_declared_coverage = '0;
    logic                  s_last_base         = 1'b0;
    logic                  s_no_base           = 1'b0;
    logic                  m_valid;
    logic                  m_ready             = 1'b0;
    logic [OUT_W-1:0]      m_count_a;
    logic [OUT_W-1:0]      m_count_c;
    logic [OUT_W-1:0]      m_count_g;
    logic [OUT_W-1:0]      m_count_t;
    logic [OUT_W-1:0]      m_count_n;
    logic [OUT_W-1:0]      m_count_deletion;
    logic [1:0]            m_status;
    logic                  psel                = 1'b0;
    logic                  penable             = 1'b0;
    logic                  pwrite              = 1'b0;
    logic [APB_ADDR_W-1:0] paddr               = '0;
    logic [APB_DATA_W-1:0] pwdata              = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pileup_base_tally u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_base_char         (s_base_char),
        .s_quality_score     (s_quality_score),
        .s_declared_coverage (s_declared_coverage),
        .s_last_base         (s_last_base),
        .s_no_base           (s_no_base),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_count_a           (m_count_a),
        .m_count_c           (m_count_c),
        .m_count_g           (m_count_g),
        .m_count_t           (m_count_t),
        .m_count_n           (m_count_n),
        .m_count_deletion    (m_count_deletion),
        .m_status            (m_status),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    pileup_item_t  base_feed_q [$];
    tally_result_t pending_tallies [$];
    pileup_item_t  on_bus;
    int            items_queued = 0;
    int            items_taken  = 0;
    int            feed_gap     = 0;
    int            ready_stall  = 0;
    int            quiet_cycles = 0;
    int            err_count    = 0;
    bit            feed_gaps    = 1'b1;
    bit            drain_gaps   = 1'b1;

    logic [7:0]    min_q_cfg    = '0;
    logic          qc_en_cfg    = 1'b0;
    logic [15:0]   lane_cnt [NUM_TALLY];
    logic [16:0]   sample_len   = '0;
    logic          bad_seen     = 1'b0;

    string lane_name [6] = '{"count_a", "count_c", "count_g", "count_t", "count_n",
                             "count_deletion"};

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void report_mismatch(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(0, 13))
            0:       return CHAR_A_UC;
            1:       return CHAR_A_LC;
            2:       return CHAR_C_UC;
            3:       return CHAR_C_LC;
            4:       return CHAR_G_UC;
            5:       return CHAR_G_LC;
            6:       return CHAR_T_UC;
            7:       return CHAR_T_LC;
            8:       return CHAR_N_UC;
            9:       return CHAR_N_LC;
            10:      return CHAR_STAR;
            11:      return CHAR_HASH;
            12:      return CHAR_LESS;
            default: return CHAR_MORE;
        endcase
    endfunction

    // Applies one accepted item to the running tallies and, when it closes
    // the sample, queues the result that the block must report.
    function automatic void tally_item(input pileup_item_t it);
        int            lane;
        int            pair;
        bit            no_real;
        tally_result_t res;
        if (!it.no_base) begin
            if (sample_len != '1) sample_len = sample_len + 1'b1;
            lane = -1;
            if (qc_en_cfg && it.quality < min_q_cfg) begin
                lane = TALLY_SKIP;
            end else begin
                case (it.base_char)
                    CHAR_A_UC, CHAR_A_LC: lane = TALLY_A;
                    CHAR_C_UC, CHAR_C_LC: lane = TALLY_C;
                    CHAR_G_UC, CHAR_G_LC: lane = TALLY_G;
                    CHAR_T_UC, CHAR_T_LC: lane = TALLY_T;
                    CHAR_N_UC, CHAR_N_LC: lane = TALLY_N;
                    CHAR_STAR, CHAR_HASH: lane = TALLY_DEL;
                    CHAR_LESS, CHAR_MORE: lane = -1;
                    default:              bad_seen = 1'b1;
                endcase
            end
            if (lane >= 0 && lane_cnt[lane] != '1) lane_cnt[lane] = lane_cnt[lane] + 1'b1;
        end
        if (it.last) begin
            no_real = 1'b1;
            for (int i = TALLY_A; i < TALLY_DEL; i++) begin
                if (lane_cnt[i] != '0) no_real = 1'b0;
            end
            pair = int'(lane_cnt[TALLY_DEL]) + int'(lane_cnt[TALLY_SKIP]);
            if (bad_seen) begin
                res.status = STATUS_BAD_CHAR;
            end else if (sample_len != {1'b0, it.coverage} && !(no_real && pair == 1)) begin
                res.status = STATUS_COV_MISMATCH;
            end else begin
                res.status = STATUS_OK;
            end
            for (int i = 0; i < 6; i++) res.cnt[i] = lane_cnt[i];
            pending_tallies = {pending_tallies, res};
            for (int i = 0; i < NUM_TALLY; i++) lane_cnt[i] = '0;
            sample_len = '0;
            bad_seen   = 1'b0;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tally_item(on_bus);
                items_taken++;
            end
            if (s_valid && !s_ready) begin
                // Hold the item until it is taken.
            end else if (feed_gap > 0) begin
                feed_gap--;
                s_valid <= 1'b0;
            end else if (base_feed_q.size() > 0) begin
                on_bus = base_feed_q.pop_front();
                s_base_char         <= on_bus.base_char;
                s_quality_score     <= on_bus.quality;
                s_declared_coverage <= on_bus.coverage;
                s_last_base         <= on_bus.last;
                s_no_base           <= on_bus.no_base;
                s_valid             <= 1'b1;
                if (feed_gaps) feed_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        tally_result_t    want;
        logic [5:0][15:0] seen;
        seen = {m_count_deletion, m_count_n, m_count_t, m_count_g, m_count_c, m_count_a};
        if (aresetn && m_valid && m_ready) begin
            if (pending_tallies.size() == 0) begin
                report_mismatch("result arrived with no sample closed");
            end else begin
                want = pending_tallies.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (seen[i] != want.cnt[i]) begin
                        report_mismatch($sformatf("%s expected %0d got %0d",
                                                  lane_name[i], want.cnt[i], seen[i]));
                    end
                end
                if (m_status != want.status) begin
                    report_mismatch($sformatf("status expected %0d got %0d",
                                              want.status, m_status));
                end
            end
        end
        if (ready_stall > 0) begin
            ready_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (drain_gaps && $urandom_range(0, 3) == 0) ready_stall = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("FAIL pileup_base_tally");
        $finish;
    end

    task automatic push_item(input logic [7:0] ch, input logic [7:0] q,
                             input logic [15:0] cov, input logic last, input logic nob);
        pileup_item_t it;
        it.base_char = ch;
        it.quality   = q;
        it.coverage  = cov;
        it.last      = last;
        it.no_base   = nob;
        base_feed_q = {base_feed_q, it};
        items_queued++;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || pending_tallies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_regs();
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, {REG_MIN_QUALITY, 2'b00}, '0, rd);
        if (rd != {24'd0, min_q_cfg}) begin
            report_mismatch($sformatf("min_quality read %0d, written %0d", rd, min_q_cfg));
        end
        apb_xfer(1'b0, {REG_QC_ENABLE, 2'b00}, '0, rd);
        if (rd != {31'd0, qc_en_cfg}) begin
            report_mismatch($sformatf("quality_check_enable read %0d, written %0d",
                                      rd, qc_en_cfg));
        end
    endtask

    task automatic set_quality(input logic [7:0] minq, input logic qc);
        logic [APB_DATA_W-1:0] rd;
        wait_drained();
        apb_xfer(1'b1, {REG_MIN_QUALITY, 2'b00}, {24'd0, minq}, rd);
        min_q_cfg = minq;
        apb_xfer(1'b1, {REG_QC_ENABLE, 2'b00}, {31'd0, qc}, rd);
        qc_en_cfg = qc;
        check_regs();
    endtask

    task automatic queue_random_sample();
        int          kind;
        int          len;
        bit          sep_close;
        logic [7:0]  ch;
        logic [7:0]  q;
        logic [15:0] cov;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // Lone deletion, or a lone random symbol, against any coverage.
            ch = $urandom_range(0, 1) ? CHAR_STAR : CHAR_HASH;
            if ($urandom_range(0, 2) == 0) ch = 8'($urandom);
            q = 8'($urandom);
            case ($urandom_range(0, 2))
                0:       cov = 16'd0;
                1:       cov = 16'd1;
                default: cov = 16'($urandom);
            endcase
            push_item(ch, q, cov, 1'b1, 1'b0);
        end else if (kind < 18) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
                push_item(8'($urandom), 8'($urandom), 16'($urandom),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
            end
        end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            sep_close = (len == 0) || ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2:  cov = $urandom_range(0, 1) ? 16'(len + 1) : 16'(len - 1);
                3, 4, 5:  cov = 16'($urandom);
                default:  cov = 16'(len);
            endcase
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 11) == 0) begin
                    push_item(8'($urandom), 8'($urandom), 16'($urandom), 1'b0, 1'b1);
                end
                ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_symbol();
                q  = ($urandom_range(0, 2) == 0) ? 8'(min_q_cfg + $urandom_range(0, 2) - 1)
                                                 : 8'($urandom);
                if (!sep_close && i == len - 1) push_item(ch, q, cov, 1'b1, 1'b0);
                else                            push_item(ch, q, 16'($urandom), 1'b0, 1'b0);
            end
            if (sep_close) push_item(8'($urandom), 8'($urandom), cov, 1'b1, 1'b1);
        end
    endtask

    initial begin
        string       mix;
        int          start;
        logic [7:0]  minq;
        logic        qc;
        for (int i = 0; i < NUM_TALLY; i++) lane_cnt[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        check_regs();

        // Empty samples, with matching and with wrong coverage.
        push_item(8'h00, 8'h00, 16'd0, 1'b1, 1'b1);
        push_item(8'hFF, 8'hFF, 16'd5, 1'b1, 1'b1);
        // Every symbol in both cases, with an ignored item inside the sample.
        mix = "AaCcGgTtNn*#<>";
        for (int i = 0; i < mix.len(); i++) begin
            if (i == 6) push_item(8'hFF, 8'hFF, 16'hFFFF, 1'b0, 1'b1);
            push_item(mix[i], 8'h00, (i == mix.len() - 1) ? 16'd14 : 16'd0,
                      i == mix.len() - 1, 1'b0);
        end
        // A single deletion is excused from the coverage check.
        push_item(CHAR_STAR, 8'h80, 16'd7, 1'b1, 1'b0);
        // An invalid symbol outranks a coverage mismatch.
        push_item(8'h78, 8'h00, 16'd0, 1'b0, 1'b0);
        push_item(CHAR_A_UC, 8'h00, 16'd9, 1'b1, 1'b0);
        push_item(8'hFF, 8'h00, 16'd1, 1'b1, 1'b0);

        set_quality(8'd30, 1'b1);
        // A filtered invalid symbol is only skipped.
        push_item(8'h51, 8'd29, 16'd0, 1'b1, 1'b0);
        push_item(CHAR_A_UC, 8'd30, 16'd0, 1'b0, 1'b0);
        push_item(CHAR_C_UC, 8'd29, 16'd2, 1'b1, 1'b0);

        set_quality(8'd255, 1'b1);
        push_item(CHAR_G_LC, 8'd255, 16'd0, 1'b0, 1'b0);
        push_item(CHAR_HASH, 8'd254, 16'd3, 1'b1, 1'b0);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       begin minq = 8'd0;   qc = 1'b1; end
                1:       begin minq = 8'd255; qc = 1'b1; end
                3:       begin minq = 8'd255; qc = 1'b0; end
                default: begin minq = 8'($urandom); qc = 1'b1; end
            endcase
            set_quality(minq, qc);
            feed_gaps  = ($urandom_range(0, 3) != 0);
            drain_gaps = ($urandom_range(0, 3) != 0);
            start = items_queued;
            while (items_queued - start < PHASE_ITEMS) queue_random_sample();
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (err_count == 0 && pending_tallies.size() == 0) begin
            $display("PASS pileup_base_tally");
        end else begin
            $display("FAIL pileup_base_tally");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pbt_pkg.sv
rtl/pbt_classify.sv
rtl/pileup_base_tally.sv
dv/tb_top.sv
